// ===== src/kway_merge_min_heap_core_assert.svh =====
// Assertion macros for the k-way merge min-heap core.
`ifndef KWAY_MERGE_MIN_HEAP_CORE_ASSERT_SVH
`define KWAY_MERGE_MIN_HEAP_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// checked while out of reset
`define KWMH_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("kwmh assertion failed");
// checked at every edge, reset included
`define KWMH_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("kwmh assertion failed");
`else
`define KWMH_ASSERT(lbl, clk, rst, prop)
`define KWMH_ASSERT_ALL(lbl, clk, prop)
`endif

`endif

// ===== src/kwmh_pkg.sv =====
// Shared types and constants for the k-way merge min-heap core.
package kwmh_pkg;

  localparam int DEF_MAX_RUNS  = 16;
  localparam int DEF_KEY_BYTES = 8;
  localparam int RUN_PORT_W    = 4;
  localparam int KEY_PORT_W    = 64;
  localparam int STATUS_W      = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_UP_CHECK,
    S_UP_WAIT,
    S_UP_CMP,
    S_POP_WAIT,
    S_POP_RES,
    S_LAST_RD,
    S_LAST_WAIT,
    S_LAST_LOAD,
    S_DN_RD,
    S_DN_WAIT,
    S_DN_CMP,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_ROOT,
    RD_PARENT,
    RD_LAST,
    RD_CHILD
  } rd_sel_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_INS,
    DP_RES_FULL,
    DP_RES_EMPTY,
    DP_UP_MOVE,
    DP_POP_RES,
    DP_POP_MV,
    DP_DN_MOVE,
    DP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    rd_sel_t rd;
  } dp_cmd_t;

  typedef struct packed {
    logic is_pop;
    logic empty;
    logic full;
    logic last_one;
    logic at_root;
    logic up_less;
    logic dn_move;
  } dp_stat_t;

endpackage

// ===== src/kwmh_dp.sv =====
// Datapath: heap order and key memories, sift registers, result registers.
`include "kway_merge_min_heap_core_assert.svh"

module kwmh_dp #(
  parameter int MAX_RUNS  = kwmh_pkg::DEF_MAX_RUNS,
  parameter int KEY_BYTES = kwmh_pkg::DEF_KEY_BYTES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            command,
  input  logic [kwmh_pkg::RUN_PORT_W-1:0] run_index,
  input  logic [kwmh_pkg::KEY_PORT_W-1:0] key,
  input  kwmh_pkg::dp_cmd_t               cmd,
  output kwmh_pkg::dp_stat_t              stat,
  output logic [kwmh_pkg::STATUS_W-1:0]   status,
  output logic [kwmh_pkg::RUN_PORT_W-1:0] out_run,
  output logic [kwmh_pkg::KEY_PORT_W-1:0] out_key,
  output logic                            done
);
  import kwmh_pkg::*;

  localparam int IW     = $clog2(MAX_RUNS);
  localparam int CW     = $clog2(MAX_RUNS + 1);
  localparam int SW     = IW + 2;
  localparam int KW     = 8 * KEY_BYTES;
  localparam int ModLim = (MAX_RUNS > 16) ? 16 : MAX_RUNS;
  localparam logic [4:0] MOD_M = 5'(ModLim);

  logic [IW-1:0] heap_order [MAX_RUNS];
  logic [KW-1:0] run_keys   [MAX_RUNS];

  logic                is_pop;
  logic [IW-1:0]       in_run;
  logic [KW-1:0]       in_key;
  logic [CW-1:0]       count;
  logic [IW-1:0]       pos;
  logic [IW-1:0]       mv_run;
  logic [KW-1:0]       mv_key;
  logic [IW-1:0]       ord_a;
  logic [IW-1:0]       ord_b;
  logic [KW-1:0]       key_a;
  logic [KW-1:0]       key_b;
  logic [STATUS_W-1:0] res_status;
  logic [IW-1:0]       res_run;
  logic [KW-1:0]       res_key;

  logic [4:0]    run_rem;
  logic [IW-1:0] run_mod;
  logic [IW-1:0] parent;
  logic [SW-1:0] left;
  logic [SW-1:0] right;
  logic [SW-1:0] count_ext;
  logic          lv;
  logic          rv;
  logic          take_l;
  logic          take_r;
  logic [KW-1:0] cur_key;
  logic [IW-1:0] child_run;
  logic [IW-1:0] child_slot;
  logic [IW-1:0] rd_a;
  logic [IW-1:0] rd_b;

  // run index modulo the run count, by repeated subtract
  always_comb begin
    run_rem = {1'b0, run_index};
    for (int i = 0; i < 8; i++) begin
      if (run_rem >= MOD_M) begin
        run_rem = run_rem - MOD_M;
      end
    end
    run_mod = IW'(run_rem);
  end

  always_comb begin
    parent    = (pos - IW'(1)) >> 1;
    left      = (SW'(pos) << 1) + SW'(1);
    right     = left + SW'(1);
    count_ext = SW'(count);
    lv        = left < count_ext;
    rv        = right < count_ext;
    take_l    = lv && (key_a < mv_key);
    cur_key   = take_l ? key_a : mv_key;
    take_r    = rv && (key_b < cur_key);
    child_run  = take_r ? ord_b : ord_a;
    child_slot = take_r ? right[IW-1:0] : left[IW-1:0];
  end

  always_comb begin
    rd_a = '0;
    rd_b = '0;
    case (cmd.rd)
      RD_ROOT:   rd_a = '0;
      RD_PARENT: rd_a = parent;
      RD_LAST:   rd_a = count[IW-1:0];
      RD_CHILD: begin
        rd_a = left[IW-1:0];
        rd_b = right[IW-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.is_pop   = is_pop;
    stat.empty    = count == '0;
    stat.full     = count == CW'(MAX_RUNS);
    stat.last_one = count == CW'(1);
    stat.at_root  = pos == '0;
    stat.up_less  = mv_key < key_a;
    stat.dn_move  = take_l || take_r;
  end

  // memory reads: order first, keys in the following cycle
  always_ff @(posedge clk) begin
    if (cmd.rd != RD_NONE) begin
      ord_a <= heap_order[rd_a];
      ord_b <= heap_order[rd_b];
    end
    key_a <= run_keys[ord_a];
    key_b <= run_keys[ord_b];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_UP_MOVE: heap_order[pos] <= ord_a;
      DP_DN_MOVE: heap_order[pos] <= child_run;
      DP_FIN:     heap_order[pos] <= mv_run;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_INS) begin
      run_keys[in_run] <= in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      case (cmd.op)
        DP_INS:     count <= count + CW'(1);
        DP_POP_RES: count <= count - CW'(1);
        default: ;
      endcase
      done <= (cmd.op == DP_INS) || (cmd.op == DP_POP_RES) ||
              (cmd.op == DP_RES_FULL) || (cmd.op == DP_RES_EMPTY);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        is_pop <= command;
        in_run <= run_mod;
        in_key <= key[KW-1:0];
      end
      DP_INS: begin
        mv_run     <= in_run;
        mv_key     <= in_key;
        pos        <= count[IW-1:0];
        res_status <= ST_OK;
        res_run    <= '0;
        res_key    <= '0;
      end
      DP_RES_FULL: begin
        res_status <= ST_FULL;
        res_run    <= '0;
        res_key    <= '0;
      end
      DP_RES_EMPTY: begin
        res_status <= ST_EMPTY;
        res_run    <= '0;
        res_key    <= '0;
      end
      DP_UP_MOVE: pos <= parent;
      DP_POP_RES: begin
        res_status <= ST_OK;
        res_run    <= ord_a;
        res_key    <= key_a;
      end
      DP_POP_MV: begin
        mv_run <= ord_a;
        mv_key <= key_a;
        pos    <= '0;
      end
      DP_DN_MOVE: pos <= child_slot;
      default: ;
    endcase
  end

  assign status  = res_status;
  assign out_run = RUN_PORT_W'(res_run);
  assign out_key = KEY_PORT_W'(res_key);

  `KWMH_ASSERT_ALL(a_done_clr, clk, rst |=> !done)
  `KWMH_ASSERT(a_count_max, clk, rst, count <= CW'(MAX_RUNS))
  `KWMH_ASSERT(a_full_flag, clk, rst, (done && res_status == ST_FULL) |-> (count == CW'(MAX_RUNS)))
  `KWMH_ASSERT(a_empty_flag, clk, rst, (done && res_status == ST_EMPTY) |-> (count == '0))

endmodule

// ===== src/kwmh_ctrl.sv =====
// Controller: sequences insert sift-up and pop sift-down over the datapath.
`include "kway_merge_min_heap_core_assert.svh"

module kwmh_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output kwmh_pkg::dp_cmd_t  cmd,
  input  kwmh_pkg::dp_stat_t stat
);
  import kwmh_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = DP_NOP;
    cmd.rd     = RD_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = DP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_pop == CMD_POP) begin
          if (stat.empty) begin
            cmd.op     = DP_RES_EMPTY;
            state_next = S_IDLE;
          end else begin
            cmd.rd     = RD_ROOT;
            state_next = S_POP_WAIT;
          end
        end else if (stat.full) begin
          cmd.op     = DP_RES_FULL;
          state_next = S_IDLE;
        end else begin
          cmd.op     = DP_INS;
          state_next = S_UP_CHECK;
        end
      end
      S_UP_CHECK: begin
        if (stat.at_root) begin
          state_next = S_FIN;
        end else begin
          cmd.rd     = RD_PARENT;
          state_next = S_UP_WAIT;
        end
      end
      S_UP_WAIT: state_next = S_UP_CMP;
      S_UP_CMP: begin
        if (stat.up_less) begin
          cmd.op     = DP_UP_MOVE;
          state_next = S_UP_CHECK;
        end else begin
          state_next = S_FIN;
        end
      end
      S_POP_WAIT: state_next = S_POP_RES;
      S_POP_RES: begin
        cmd.op     = DP_POP_RES;
        state_next = stat.last_one ? S_IDLE : S_LAST_RD;
      end
      S_LAST_RD: begin
        cmd.rd     = RD_LAST;
        state_next = S_LAST_WAIT;
      end
      S_LAST_WAIT: state_next = S_LAST_LOAD;
      S_LAST_LOAD: begin
        cmd.op     = DP_POP_MV;
        state_next = S_DN_RD;
      end
      S_DN_RD: begin
        cmd.rd     = RD_CHILD;
        state_next = S_DN_WAIT;
      end
      S_DN_WAIT: state_next = S_DN_CMP;
      S_DN_CMP: begin
        if (stat.dn_move) begin
          cmd.op     = DP_DN_MOVE;
          state_next = S_DN_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.op     = DP_FIN;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = state != S_IDLE;

  `KWMH_ASSERT_ALL(a_rst_idle, clk, rst |=> (state == S_IDLE))
  `KWMH_ASSERT(a_accept, clk, rst, (start && !busy) |=> (state == S_DECIDE))
  `KWMH_ASSERT(a_fin_idle, clk, rst, (state == S_FIN) |=> (state == S_IDLE))
  `KWMH_ASSERT(a_empty_pop, clk, rst, (state == S_DECIDE && stat.is_pop && stat.empty) |=> (state == S_IDLE))

endmodule

// ===== src/kway_merge_min_heap_core.sv =====
// Top level of the k-way merge min-heap core.
//
// channel  dir  handshake              fields
// request  in   start && !busy         command, run_index, key
// result   out  done, one cycle only   status, out_run, out_key
//
// done is registered from S_DECIDE, or for a successful pop from S_POP_RES
// after the root read. An insert climbs via S_UP_CHECK, S_UP_WAIT, S_UP_CMP
// per level; a pop that leaves entries loads the last one and descends via
// S_DN_RD, S_DN_WAIT, S_DN_CMP per level (heap_order, then run_keys read).
// Synchronous rst clears the state machine, the entry count and done; the
// memories are not cleared. The result side has no stall: done is one pulse.
module kway_merge_min_heap_core #(
  parameter int MAX_RUNS  = kwmh_pkg::DEF_MAX_RUNS,
  parameter int KEY_BYTES = kwmh_pkg::DEF_KEY_BYTES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            command,
  input  logic [kwmh_pkg::RUN_PORT_W-1:0] run_index,
  input  logic [kwmh_pkg::KEY_PORT_W-1:0] key,
  output logic                            done,
  output logic [kwmh_pkg::STATUS_W-1:0]   status,
  output logic [kwmh_pkg::RUN_PORT_W-1:0] out_run,
  output logic [kwmh_pkg::KEY_PORT_W-1:0] out_key
);
  import kwmh_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  kwmh_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  kwmh_dp #(
    .MAX_RUNS  (MAX_RUNS),
    .KEY_BYTES (KEY_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .command   (command),
    .run_index (run_index),
    .key       (key),
    .cmd       (cmd),
    .stat      (stat),
    .status    (status),
    .out_run   (out_run),
    .out_key   (out_key),
    .done      (done)
  );

endmodule
